// ===== rtl/core/tia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_pkg: shared types and constants of the typed integer ALU
// Operation codes, channel words and the word that travels down the pipeline.
// ----------------------------------------------------------------------------
package tia_pkg;

	localparam logic [4:0] OP_MOV  = 5'd0;
	localparam logic [4:0] OP_ADD  = 5'd1;
	localparam logic [4:0] OP_SUB  = 5'd2;
	localparam logic [4:0] OP_MUL  = 5'd3;
	localparam logic [4:0] OP_DIV  = 5'd4;
	localparam logic [4:0] OP_MOD  = 5'd5;
	localparam logic [4:0] OP_OR   = 5'd6;
	localparam logic [4:0] OP_AND  = 5'd7;
	localparam logic [4:0] OP_XOR  = 5'd8;
	localparam logic [4:0] OP_NOT  = 5'd9;
	localparam logic [4:0] OP_LNOT = 5'd10;
	localparam logic [4:0] OP_SHL  = 5'd11;
	localparam logic [4:0] OP_SHR  = 5'd12;
	localparam logic [4:0] OP_LT   = 5'd13;
	localparam logic [4:0] OP_LE   = 5'd14;
	localparam logic [4:0] OP_GT   = 5'd15;
	localparam logic [4:0] OP_GE   = 5'd16;
	localparam logic [4:0] OP_EQ   = 5'd17;
	localparam logic [4:0] OP_NE   = 5'd18;

	// Kind encoding: bit 1 set for unsigned, bit 0 set for 32-bit.
	localparam logic signed [32:0] SHIFT_LIMIT = 33'sd1000;

	// One quotient bit per divider stage; magnitudes stay below 2^32.
	localparam int DIV_BITS = 33;

	typedef struct packed {
		logic [4:0]  req_type;
		logic [31:0] left_value;
		logic [1:0]  left_kind;
		logic [31:0] right_value;
		logic [1:0]  right_kind;
	} req_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        shift_error;
	} rsp_t;

	typedef struct packed {
		logic [4:0]  op;
		logic [1:0]  lkind;
		logic [31:0] simple;
		logic        err;
		logic        q_neg;
		logic        r_neg;
		logic        d_zero;
		logic [32:0] n;
		logic [32:0] d;
		logic [32:0] rem;
		logic [32:0] quo;
	} work_t;

	function automatic logic [31:0] crop(input logic [1:0] kind, input logic [31:0] v);
		return kind[0] ? v : {24'd0, v[7:0]};
	endfunction

endpackage

// ===== rtl/core/tia_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_stream_if: valid/ready channel
// Carries one word when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface tia_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/typed_integer_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_integer_alu: integer ALU for typed 8/32-bit operands
// Widen, operate, crop to the left kind; divide and modulo fully pipelined.
// ----------------------------------------------------------------------------
//  channel  side  word
//  req      in    req_type, left_value, left_kind, right_value, right_kind
//  rsp      out   result_value, shift_error
//
// Every operation passes one front stage, 33 divider stages (one quotient
// bit each) and the output register. A new word is taken every cycle while
// rsp does not stall. Each stage advances when it is empty or its successor
// advances, so bubbles close up and a stalled rsp holds its word while
// upstream keeps filling. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module typed_integer_alu (
	input  logic       clk,
	input  logic       arst_n,
	tia_stream_if.sink   req,
	tia_stream_if.source rsp
);
	import tia_pkg::*;

	// Front stage to divider: all results but divide and modulo are final here.
	logic  f_valid;
	logic  f_ready;
	work_t f_data;

	// Divider to output stage: quotient and remainder magnitudes complete.
	logic  d_valid;
	logic  d_ready;
	work_t d_data;

	tia_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	tia_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_data  (d_data)
	);

	tia_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d_valid),
		.in_ready (d_ready),
		.in_data  (d_data),
		.rsp      (rsp)
	);
endmodule

// ===== rtl/core/tia_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_front: operand widening and all operations but divide and modulo
// Widen both operands, evaluate all but divide and modulo, set up the divider.
// ----------------------------------------------------------------------------
module tia_front (
	input  logic                 clk,
	input  logic                 arst_n,
	tia_stream_if.sink           req,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tia_pkg::work_t       out_data
);
	import tia_pkg::*;

	logic               v_s1;
	work_t              w_s1;
	logic               take;
	work_t              w;
	logic signed [32:0] a;
	logic signed [32:0] b;
	logic [63:0]        a64;
	logic [31:0]        prod;
	logic [31:0]        r;
	logic               err;
	logic               sh_ok;

	// Signed kinds sign-extend, unsigned kinds zero-extend, to 33 bits.
	always_comb begin
		unique case (req.data.left_kind)
			2'd0: a = {{25{req.data.left_value[7]}}, req.data.left_value[7:0]};
			2'd1: a = {req.data.left_value[31], req.data.left_value};
			2'd2: a = {25'd0, req.data.left_value[7:0]};
			default: a = {1'b0, req.data.left_value};
		endcase
		unique case (req.data.right_kind)
			2'd0: b = {{25{req.data.right_value[7]}}, req.data.right_value[7:0]};
			2'd1: b = {req.data.right_value[31], req.data.right_value};
			2'd2: b = {25'd0, req.data.right_value[7:0]};
			default: b = {1'b0, req.data.right_value};
		endcase
	end

	assign a64   = {{31{a[32]}}, a};
	assign prod  = a[31:0] * b[31:0];
	assign sh_ok = !b[32] && (b[31:6] == 26'd0);

	always_comb begin
		r   = 32'd0;
		err = 1'b0;
		case (req.data.req_type) inside
			OP_MOV:  r = crop(req.data.left_kind, b[31:0]);
			OP_ADD:  r = crop(req.data.left_kind, a[31:0] + b[31:0]);
			OP_SUB:  r = crop(req.data.left_kind, a[31:0] - b[31:0]);
			OP_MUL:  r = crop(req.data.left_kind, prod);
			OP_OR:   r = crop(req.data.left_kind, a[31:0] | b[31:0]);
			OP_AND:  r = crop(req.data.left_kind, a[31:0] & b[31:0]);
			OP_XOR:  r = crop(req.data.left_kind, a[31:0] ^ b[31:0]);
			OP_NOT:  r = crop(req.data.left_kind, ~a[31:0]);
			OP_LNOT: r = {31'd0, a == 33'sd0};
			OP_SHL, OP_SHR: begin
				if (b > SHIFT_LIMIT || b < -SHIFT_LIMIT) begin
					err = 1'b1;
				end else if (sh_ok) begin
					if (req.data.req_type == OP_SHL) begin
						r = crop(req.data.left_kind, 32'(a64 << b[5:0]));
					end else begin
						r = crop(req.data.left_kind, 32'(a64 >> b[5:0]));
					end
				end
			end
			OP_LT:   r = {31'd0, $unsigned(a) <  $unsigned(b)};
			OP_LE:   r = {31'd0, $unsigned(a) <= $unsigned(b)};
			OP_GT:   r = {31'd0, $unsigned(a) >  $unsigned(b)};
			OP_GE:   r = {31'd0, $unsigned(a) >= $unsigned(b)};
			OP_EQ:   r = {31'd0, a == b};
			OP_NE:   r = {31'd0, a != b};
			default: r = 32'd0;
		endcase
	end

	always_comb begin
		w        = '0;
		w.op     = req.data.req_type;
		w.lkind  = req.data.left_kind;
		w.simple = r;
		w.err    = err;
		w.q_neg  = a[32] ^ b[32];
		w.r_neg  = a[32];
		w.d_zero = (b == 33'sd0);
		w.n      = a[32] ? 33'(-a) : a;
		w.d      = b[32] ? 33'(-b) : b;
	end

	assign take      = !v_s1 || out_ready;
	assign req.ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && req.valid) begin
			w_s1 <= w;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = w_s1;
endmodule

// ===== rtl/core/tia_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_div_pipe: pipelined restoring divider
// One quotient bit per stage on magnitudes; other results ride along.
// ----------------------------------------------------------------------------
module tia_div_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tia_pkg::work_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tia_pkg::work_t out_data
);
	import tia_pkg::*;

	logic  v_s    [DIV_BITS];
	work_t w_s    [DIV_BITS];
	logic  take   [DIV_BITS];

	function automatic work_t div_step(input work_t s);
		work_t       o;
		logic [33:0] t;
		logic        ge;
		o      = s;
		t      = {s.rem, s.n[32]};
		ge     = t >= {1'b0, s.d};
		o.rem  = ge ? 33'(t - {1'b0, s.d}) : t[32:0];
		o.n    = {s.n[31:0], 1'b0};
		o.quo  = {s.quo[31:0], ge};
		return o;
	endfunction

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
		logic  v_in;
		work_t w_in;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign w_in = in_data;
		end else begin : g_next
			assign v_in = v_s[i-1];
			assign w_in = w_s[i-1];
		end

		if (i == DIV_BITS - 1) begin : g_last
			assign take[i] = !v_s[i] || out_ready;
		end else begin : g_mid
			assign take[i] = !v_s[i] || take[i+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (take[i]) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (take[i] && v_in) begin
				w_s[i] <= div_step(w_in);
			end
		end
	end

	assign in_ready  = take[0];
	assign out_valid = v_s[DIV_BITS-1];
	assign out_data  = w_s[DIV_BITS-1];
endmodule

// ===== rtl/core/tia_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_back: sign fix-up, result select and output register
// Restore quotient and remainder signs, crop, and hold the result word.
// ----------------------------------------------------------------------------
module tia_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tia_pkg::work_t in_data,
	tia_stream_if.source   rsp
);
	import tia_pkg::*;

	logic        v_q;
	rsp_t        rsp_q;
	rsp_t        nxt;
	logic        take;
	logic [32:0] q_val;
	logic [32:0] r_val;

	assign q_val = in_data.q_neg ? 33'(-in_data.quo) : in_data.quo;
	assign r_val = in_data.r_neg ? 33'(-in_data.rem) : in_data.rem;

	always_comb begin
		nxt.shift_error = in_data.err;
		if (in_data.op == OP_DIV) begin
			nxt.result_value = in_data.d_zero ? 32'd0 : crop(in_data.lkind, q_val[31:0]);
		end else if (in_data.op == OP_MOD) begin
			nxt.result_value = in_data.d_zero ? 32'd0 : crop(in_data.lkind, r_val[31:0]);
		end else begin
			nxt.result_value = in_data.simple;
		end
	end

	assign take     = !v_q || rsp.ready;
	assign in_ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			rsp_q <= nxt;
		end
	end

	assign rsp.valid = v_q;
	assign rsp.data  = rsp_q;
endmodule
